### hw/rtl/hsl2rgb_pkg.sv
// Constants and types shared by the HSL to RGB conversion pipeline.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

    localparam int HUE_W    = 9;   // hue in whole degrees
    localparam int PCT_W    = 7;   // saturation and lightness in percent
    localparam int CHAN_W   = 8;   // one output color channel
    localparam int UNIT_W   = 14;  // q, p and q - p in units of 1/10000
    localparam int WIDE_W   = 15;  // intermediate sums up to 20000
    localparam int VAL_W    = 20;  // channel value in units of 1/600000
    localparam int SCALED_W = 24;  // value * 17 + rounding bias
    localparam int QUOT_W   = 18;  // scaled value after the shift by 6
    localparam int RECIP_W  = 19;  // width of the reciprocal constant
    localparam int PROD_W   = QUOT_W + RECIP_W;
    localparam int NUM_CHAN = 3;

    localparam logic [HUE_W-1:0] HUE_MAX   = 9'd360;
    localparam logic [HUE_W-1:0] THIRD_DEG = 9'd120;
    localparam logic [HUE_W-1:0] SEG_DEG   = 9'd60;
    localparam logic [HUE_W-1:0] HALF_DEG  = 9'd180;
    localparam logic [HUE_W-1:0] TWO3_DEG  = 9'd240;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF  = 7'd50;

    // Byte = floor((v * 17 + 20000) / 40000) = floor(((v * 17 + 20000) >> 6) / 625).
    // The division by 625 is a multiply by ceil(2^28 / 625) and a shift by 28,
    // exact for every quotient input below 2^18.
    localparam logic [4:0]          SCALE_MUL   = 5'd17;
    localparam logic [SCALED_W-1:0] ROUND_BIAS  = 24'd20000;
    localparam int                  PRE_SHIFT   = 6;
    localparam logic [RECIP_W-1:0]  RECIP_M     = 19'd429497;
    localparam int                  RECIP_SHIFT = 28;
    localparam logic [CHAN_W-1:0]   CHAN_MAX    = 8'd255;

    typedef logic [HUE_W-1:0]  hue_t;
    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [VAL_W-1:0]  val_t;

endpackage

### hw/rtl/hsl_to_rgb_converter.sv
// HSL to RGB color converter: five-stage pipeline, one item per clock when the output drains.
`timescale 1ns / 1ps

//  channel | direction | tdata bits (low to high)                    | tuser/tlast
//  s_axis  | in        | [8:0] hue_deg, [15:9] sat_pct, [22:16] light_pct | none
//  m_axis  | out       | [7:0] red, [15:8] green, [23:16] blue           | none
//
//  Every item passes through five register stages: q, p/d and shifted hues,
//  channel value, scaled value, reciprocal multiply into the output register.
//  One item is taken per clock when the output drains.
//  aresetn (synchronous, active low) clears only the stage valid bits.
//  A stall on m_axis_tready holds every stage at once; nothing is dropped or
//  repeated, and s_axis_tready follows the output side within the same cycle.
module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hue_deg[8:0], sat_pct[15:9], light_pct[22:16]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    // Channel value for shifted hue t: rise, plateau at q, fall, floor at p.
    function automatic val_t seg_value(input unit_t p, input unit_t d, input hue_t t);
        logic [HUE_W-1:0]  tx;
        logic [VAL_W-1:0]  base;
        logic [VAL_W-1:0]  ramp;
        begin
            tx   = '0;
            base = VAL_W'(p) * VAL_W'(SEG_DEG);
            if (t < SEG_DEG) begin
                tx = t;
            end else if (t < HALF_DEG) begin
                tx = SEG_DEG;
            end else if (t < TWO3_DEG) begin
                tx = TWO3_DEG - t;
            end
            ramp = VAL_W'(d) * VAL_W'(tx);
            seg_value = base + ramp;
        end
    endfunction

    // Advance the whole pipeline unless the output holds an untaken item.
    logic adv;
    assign adv           = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = adv;

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 1: clamp and form q.
    logic [HUE_W-1:0]  h_in;
    logic [PCT_W-1:0]  s_in, l_in, s_c, l_c;
    hue_t              h_c;
    logic [WIDE_W-1:0] q_wide;
    hue_t              h1_reg;
    logic [PCT_W-1:0]  l1_reg;
    unit_t             q1_reg;

    assign h_in = s_axis_tdata[8:0];
    assign s_in = s_axis_tdata[15:9];
    assign l_in = s_axis_tdata[22:16];

    always_comb begin
        h_c = (h_in > HUE_MAX) ? HUE_MAX : h_in;
        s_c = (s_in > PCT_MAX) ? PCT_MAX : s_in;
        l_c = (l_in > PCT_MAX) ? PCT_MAX : l_in;
        if (l_c < PCT_HALF) begin
            q_wide = WIDE_W'(l_c) * (WIDE_W'(PCT_MAX) + WIDE_W'(s_c));
        end else begin
            q_wide = WIDE_W'(PCT_MAX) * WIDE_W'(l_c) + WIDE_W'(PCT_MAX) * WIDE_W'(s_c)
                   - WIDE_W'(l_c) * WIDE_W'(s_c);
        end
    end

    // Stage 2: p, d = q - p, and the three shifted hues (red, green, blue).
    logic [WIDE_W-1:0] p_wide;
    unit_t             p_c, d_c;
    logic [HUE_W:0]    tr_sum;
    hue_t              t_c [NUM_CHAN];
    unit_t             p2_reg, d2_reg;
    hue_t              t2_reg [NUM_CHAN];

    always_comb begin
        p_wide = WIDE_W'(l1_reg) * WIDE_W'(2 * PCT_MAX) - WIDE_W'(q1_reg);
        p_c    = p_wide[UNIT_W-1:0];
        d_c    = q1_reg - p_c;
        tr_sum = {1'b0, h1_reg} + {1'b0, THIRD_DEG};
        // A shifted hue equal to one full turn is kept, not wrapped.
        t_c[0] = (tr_sum > {1'b0, HUE_MAX}) ? HUE_W'(tr_sum - {1'b0, HUE_MAX})
                                            : tr_sum[HUE_W-1:0];
        t_c[1] = h1_reg;
        t_c[2] = (h1_reg < THIRD_DEG) ? h1_reg + (HUE_MAX - THIRD_DEG)
                                      : h1_reg - THIRD_DEG;
    end

    // Stage 3: channel values; stage 4: scale and bias; stage 5: divide by 625.
    val_t                v3_val_reg [NUM_CHAN];
    logic [QUOT_W-1:0]   y4_reg     [NUM_CHAN];
    logic [CHAN_W-1:0]   rgb5_reg   [NUM_CHAN];
    logic [SCALED_W-1:0] scaled_c   [NUM_CHAN];
    logic [PROD_W-1:0]   prod_c     [NUM_CHAN];
    logic [PROD_W-RECIP_SHIFT-1:0] byte_c [NUM_CHAN];

    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            scaled_c[i] = SCALED_W'(v3_val_reg[i]) * SCALED_W'(SCALE_MUL) + ROUND_BIAS;
            prod_c[i]   = PROD_W'(y4_reg[i]) * PROD_W'(RECIP_M);
            byte_c[i]   = prod_c[i][PROD_W-1:RECIP_SHIFT];
        end
    end

    // Valid bits: hold on stall, clear on reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Payload: advance with the valid bits, no reset needed.
    always_ff @(posedge aclk) begin
        if (adv) begin
            h1_reg <= h_c;
            l1_reg <= l_c;
            q1_reg <= q_wide[UNIT_W-1:0];
            p2_reg <= p_c;
            d2_reg <= d_c;
            for (int i = 0; i < NUM_CHAN; i++) begin
                t2_reg[i]     <= t_c[i];
                v3_val_reg[i] <= seg_value(p2_reg, d2_reg, t2_reg[i]);
                y4_reg[i]     <= scaled_c[i][SCALED_W-1:PRE_SHIFT];
                rgb5_reg[i]   <= (byte_c[i] > (PROD_W-RECIP_SHIFT)'(CHAN_MAX))
                               ? CHAN_MAX : byte_c[i][CHAN_W-1:0];
            end
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {rgb5_reg[2], rgb5_reg[1], rgb5_reg[0]};

endmodule
